### design/snell_refraction_direction_assert.svh
// Assertion macros used by the checker file of the refraction block.
`ifndef SNELL_REFRACTION_DIRECTION_ASSERT_SVH
`define SNELL_REFRACTION_DIRECTION_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("snell_refraction_direction: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("snell_refraction_direction: next-cycle check failed");

`endif

### design/srd_pkg.sv
// Types and constants shared by the refraction pipeline.
package srd_pkg;

    localparam int COMP_W    = 18;
    localparam int NORM_W    = 19;
    localparam int IOR_W     = 16;
    localparam int C_W       = 17;
    localparam int ETA_W     = 29;
    localparam int EC_W      = ETA_W + C_W;
    localparam int K_W       = 33;
    localparam int ROOT_W    = 18;

    localparam int DIV_STEPS     = 32;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
    localparam logic [DIV_STEPS-1:0] DIV_NUM = 32'h1000_0000;

    localparam int SQRT_W         = 36;
    localparam int SQRT_ITER      = SQRT_W / 2;
    localparam int SQRT_PER_STAGE = 3;
    localparam int SQRT_STAGES    = SQRT_ITER / SQRT_PER_STAGE;
    localparam int SQRT_REM_W     = 21;

    localparam logic signed [63:0] OUT_MAX = 64'sd131071;
    localparam logic signed [63:0] OUT_MIN = -64'sd131072;

    typedef struct packed {
        logic signed [COMP_W-1:0] ix;
        logic signed [COMP_W-1:0] iy;
        logic signed [COMP_W-1:0] iz;
        logic signed [COMP_W-1:0] nx;
        logic signed [COMP_W-1:0] ny;
        logic signed [COMP_W-1:0] nz;
        logic [IOR_W-1:0]         raw;
    } t_hit;

    typedef struct packed {
        logic signed [COMP_W-1:0] ix;
        logic signed [COMP_W-1:0] iy;
        logic signed [COMP_W-1:0] iz;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [C_W-1:0]           c;
        logic                     leaving;
        logic [IOR_W-1:0]         raw;
    } t_geo;

    typedef struct packed {
        logic signed [COMP_W-1:0] ix;
        logic signed [COMP_W-1:0] iy;
        logic signed [COMP_W-1:0] iz;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
        logic [ETA_W-1:0]         eta;
        logic [EC_W-1:0]          ec;
        logic                     reflect;
    } t_ray;

endpackage

### design/srd_dot.sv
// Dot product, clamp, cosine magnitude and normal flip (two stages).
module srd_dot (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  srd_pkg::t_hit i_hit,
    output logic          o_valid,
    output srd_pkg::t_geo o_geo
);
    import srd_pkg::*;

    logic                 r_v1;
    t_hit                 r_hit;
    logic signed [35:0]   r_px, r_py, r_pz;
    logic signed [37:0]   n_d, n_dc, n_mag;
    t_geo                 n_geo;
    t_geo                 r_geo;
    logic                 r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= i_hit;
            r_px  <= i_hit.ix * i_hit.nx;
            r_py  <= i_hit.iy * i_hit.ny;
            r_pz  <= i_hit.iz * i_hit.nz;
            r_geo <= n_geo;
        end
    end

    always_comb begin
        n_d = 38'(r_px) + 38'(r_py) + 38'(r_pz);
        if (n_d > 38'sd4294967296) begin
            n_dc = 38'sd4294967296;
        end else if (n_d < -38'sd4294967296) begin
            n_dc = -38'sd4294967296;
        end else begin
            n_dc = n_d;
        end
        n_geo.leaving = (n_dc > 38'sd0);
        n_mag         = n_geo.leaving ? n_dc : -n_dc;
        n_geo.c       = n_mag[32:16];
        n_geo.ix      = r_hit.ix;
        n_geo.iy      = r_hit.iy;
        n_geo.iz      = r_hit.iz;
        n_geo.nx      = n_geo.leaving ? -NORM_W'(r_hit.nx) : NORM_W'(r_hit.nx);
        n_geo.ny      = n_geo.leaving ? -NORM_W'(r_hit.ny) : NORM_W'(r_hit.ny);
        n_geo.nz      = n_geo.leaving ? -NORM_W'(r_hit.nz) : NORM_W'(r_hit.nz);
        n_geo.raw     = r_hit.raw;
    end

    assign o_valid = r_v2;
    assign o_geo   = r_geo;
endmodule

### design/srd_div.sv
// Pipelined restoring divider for the entering index ratio 2^28 / ior.
module srd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  srd_pkg::t_geo             i_geo,
    output logic                      o_valid,
    output srd_pkg::t_geo             o_geo,
    output logic [srd_pkg::ETA_W-1:0] o_quot
);
    import srd_pkg::*;

    logic                 r_v   [DIV_STAGES];
    t_geo                 r_geo [DIV_STAGES];
    logic [IOR_W-1:0]     r_rem [DIV_STAGES];
    logic [DIV_STEPS-1:0] r_q   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic                 v_in;
        t_geo                 geo_in;
        logic [IOR_W-1:0]     rem_in;
        logic [DIV_STEPS-1:0] q_in;
        logic [IOR_W-1:0]     n_rem;
        logic [DIV_STEPS-1:0] n_q;
        logic [IOR_W:0]       n_t;
        logic [IOR_W-1:0]     n_dv;

        if (s == 0) begin : g_first
            assign v_in   = i_valid;
            assign geo_in = i_geo;
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[s-1];
            assign geo_in = r_geo[s-1];
            assign rem_in = r_rem[s-1];
            assign q_in   = r_q[s-1];
        end

        always_comb begin
            n_dv  = (geo_in.raw == '0) ? IOR_W'(1) : geo_in.raw;
            n_rem = rem_in;
            n_q   = q_in;
            n_t   = '0;
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                n_t = {n_rem, DIV_NUM[DIV_STEPS-1-s*DIV_PER_STAGE-j]};
                if (n_t >= {1'b0, n_dv}) begin
                    n_t = n_t - {1'b0, n_dv};
                    n_q[DIV_STEPS-1-s*DIV_PER_STAGE-j] = 1'b1;
                end
                n_rem = n_t[IOR_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_geo[s] <= geo_in;
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_geo   = r_geo[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1][ETA_W-1:0];
endmodule

### design/srd_kcalc.sv
// Index ratio select, eta^2 (1 - cos^2) and the radicand k (three stages).
module srd_kcalc (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  srd_pkg::t_geo             i_geo,
    input  logic [srd_pkg::ETA_W-1:0] i_quot,
    output logic                      o_valid,
    output srd_pkg::t_ray             o_ray,
    output logic [srd_pkg::K_W-1:0]   o_k
);
    import srd_pkg::*;

    logic             r_v1, r_v2, r_v3;
    t_ray             r_ray1, r_ray2, r_ray3;
    logic [57:0]      r_eta2;
    logic [32:0]      r_s1;
    logic [58:0]      r_ph;
    logic [64:0]      r_pl;
    logic [K_W-1:0]   r_k;
    logic [ETA_W-1:0] n_eta;
    logic [33:0]      n_cc;
    t_ray             n_ray1, n_ray3;
    logic [90:0]      n_p;
    logic [64:0]      n_diff;
    logic [K_W-1:0]   n_k;

    always_comb begin
        n_eta        = i_geo.leaving ? ETA_W'({i_geo.raw, 4'b0}) : i_quot;
        n_cc         = i_geo.c * i_geo.c;
        n_ray1.ix    = i_geo.ix;
        n_ray1.iy    = i_geo.iy;
        n_ray1.iz    = i_geo.iz;
        n_ray1.nx    = i_geo.nx;
        n_ray1.ny    = i_geo.ny;
        n_ray1.nz    = i_geo.nz;
        n_ray1.eta   = n_eta;
        n_ray1.ec    = n_eta * i_geo.c;
        n_ray1.reflect = 1'b0;
    end

    always_comb begin
        n_p    = {r_ph, 32'b0} + 91'(r_pl);
        n_ray3 = r_ray2;
        n_ray3.reflect = (n_p > 91'h1_0000_0000_0000_0000);
        n_diff = 65'h1_0000_0000_0000_0000 - n_p[64:0];
        n_k    = n_ray3.reflect ? '0 : n_diff[64:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ray1 <= n_ray1;
            r_eta2 <= n_eta * n_eta;
            r_s1   <= 33'h1_0000_0000 - 33'(n_cc);
            r_ray2 <= r_ray1;
            r_ph   <= r_eta2[57:32] * r_s1;
            r_pl   <= r_eta2[31:0] * r_s1;
            r_ray3 <= n_ray3;
            r_k    <= n_k;
        end
    end

    assign o_valid = r_v3;
    assign o_ray   = r_ray3;
    assign o_k     = r_k;
endmodule

### design/srd_sqrt.sv
// Pipelined digit-by-digit integer square root of k.
module srd_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  srd_pkg::t_ray              i_ray,
    input  logic [srd_pkg::K_W-1:0]    i_k,
    output logic                       o_valid,
    output srd_pkg::t_ray              o_ray,
    output logic [srd_pkg::ROOT_W-1:0] o_root
);
    import srd_pkg::*;

    logic                  r_v    [SQRT_STAGES];
    t_ray                  r_ray  [SQRT_STAGES];
    logic [SQRT_W-1:0]     r_rad  [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]     r_root [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic                  v_in;
        t_ray                  ray_in;
        logic [SQRT_W-1:0]     rad_in;
        logic [SQRT_REM_W-1:0] rem_in;
        logic [ROOT_W-1:0]     root_in;
        logic [SQRT_REM_W-1:0] n_rem;
        logic [SQRT_REM_W-1:0] n_trial;
        logic [ROOT_W-1:0]     n_root;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign ray_in  = i_ray;
            assign rad_in  = SQRT_W'(i_k);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign ray_in  = r_ray[s-1];
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        always_comb begin
            n_rem   = rem_in;
            n_root  = root_in;
            n_trial = '0;
            for (int j = 0; j < SQRT_PER_STAGE; j++) begin
                n_rem   = {n_rem[SQRT_REM_W-3:0],
                           rad_in[SQRT_W-1-2*(s*SQRT_PER_STAGE+j) -: 2]};
                n_trial = SQRT_REM_W'({n_root, 2'b01});
                if (n_rem >= n_trial) begin
                    n_rem  = n_rem - n_trial;
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ray[s]  <= ray_in;
                r_rad[s]  <= rad_in;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_valid = r_v[SQRT_STAGES-1];
    assign o_ray   = r_ray[SQRT_STAGES-1];
    assign o_root  = r_root[SQRT_STAGES-1];
endmodule

### design/srd_out.sv
// Refracted vector eta*I + coef*n, rounding, saturation and result register.
module srd_out (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  srd_pkg::t_ray               i_ray,
    input  logic [srd_pkg::ROOT_W-1:0]  i_root,
    output logic                        o_valid,
    output logic [srd_pkg::COMP_W-1:0]  o_x,
    output logic [srd_pkg::COMP_W-1:0]  o_y,
    output logic [srd_pkg::COMP_W-1:0]  o_z,
    output logic                        o_reflect
);
    import srd_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic               r_refl1, r_refl2;
    logic signed [46:0] r_cf;
    logic signed [47:0] r_ei1 [3];
    logic signed [47:0] r_ei2 [3];
    logic signed [NORM_W-1:0] r_n [3];
    logic signed [42:0] r_plo [3];
    logic signed [42:0] r_phi [3];
    logic [COMP_W-1:0]  r_out [3];
    logic               r_refl3;
    logic signed [46:0] n_cf;
    logic signed [COMP_W-1:0] n_i [3];
    logic signed [NORM_W-1:0] n_n [3];
    logic [COMP_W-1:0]  n_out [3];

    always_comb begin
        n_cf   = $signed({1'b0, i_ray.ec}) - $signed({13'b0, i_root, 16'b0});
        n_i[0] = i_ray.ix;
        n_i[1] = i_ray.iy;
        n_i[2] = i_ray.iz;
        n_n[0] = i_ray.nx;
        n_n[1] = i_ray.ny;
        n_n[2] = i_ray.nz;
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
        logic signed [63:0] e64, h64, l64, v, t, q;

        always_comb begin
            e64 = r_ei2[j];
            h64 = r_phi[j];
            l64 = r_plo[j];
            v   = (e64 <<< 16) + (h64 <<< 23) + l64;
            t   = v + 64'sd2147483648;
            q   = t >>> 32;
            if (r_refl2) begin
                n_out[j] = '0;
            end else if (q > OUT_MAX) begin
                n_out[j] = OUT_MAX[COMP_W-1:0];
            end else if (q < OUT_MIN) begin
                n_out[j] = OUT_MIN[COMP_W-1:0];
            end else begin
                n_out[j] = q[COMP_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ei1[j] <= $signed({1'b0, i_ray.eta}) * n_i[j];
                r_n[j]   <= n_n[j];
                r_ei2[j] <= r_ei1[j];
                r_plo[j] <= $signed({1'b0, r_cf[22:0]}) * r_n[j];
                r_phi[j] <= $signed(r_cf[46:23]) * r_n[j];
                r_out[j] <= n_out[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cf    <= n_cf;
            r_refl1 <= i_ray.reflect;
            r_refl2 <= r_refl1;
            r_refl3 <= r_refl2;
        end
    end

    assign o_valid   = r_v3;
    assign o_x       = r_out[0];
    assign o_y       = r_out[1];
    assign o_z       = r_out[2];
    assign o_reflect = r_refl3;
endmodule

### design/snell_refraction_direction.sv
// Top level of the refraction direction pipeline.
// The block takes one transfer per clock and returns each result in order, after
// the dot product, the divider that forms 2^28 / ior at four quotient bits per
// stage, the radicand, the square root at three root bits per stage and the
// final vector, rounding and saturation. The whole pipeline advances together;
// it stalls only while a finished result waits at the output.
module snell_refraction_direction (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // inc_x, inc_y, inc_z, norm_x, norm_y, norm_z, index_ratio_in, zero pad
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_z, zero pad
    output logic [55:0]  m_axis_tdata,
    // total_reflect
    output logic         m_axis_tuser
);
    import srd_pkg::*;

    logic             en;
    t_hit             hit;
    logic             dot_v, div_v, k_v, sq_v, out_v;
    t_geo             dot_geo, div_geo;
    logic [ETA_W-1:0] quot;
    t_ray             k_ray, sq_ray;
    logic [K_W-1:0]   k;
    logic [ROOT_W-1:0] root;
    logic [COMP_W-1:0] ox, oy, oz;
    logic             refl;

    assign en = !out_v || m_axis_tready;
    assign s_axis_tready = en;

    assign hit.ix  = s_axis_tdata[17:0];
    assign hit.iy  = s_axis_tdata[35:18];
    assign hit.iz  = s_axis_tdata[53:36];
    assign hit.nx  = s_axis_tdata[71:54];
    assign hit.ny  = s_axis_tdata[89:72];
    assign hit.nz  = s_axis_tdata[107:90];
    assign hit.raw = s_axis_tdata[123:108];

    srd_dot u_dot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid), .i_hit(hit),
        .o_valid(dot_v), .o_geo(dot_geo)
    );

    srd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(dot_v), .i_geo(dot_geo),
        .o_valid(div_v), .o_geo(div_geo), .o_quot(quot)
    );

    srd_kcalc u_kcalc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(div_v), .i_geo(div_geo), .i_quot(quot),
        .o_valid(k_v), .o_ray(k_ray), .o_k(k)
    );

    srd_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(k_v), .i_ray(k_ray), .i_k(k),
        .o_valid(sq_v), .o_ray(sq_ray), .o_root(root)
    );

    srd_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(sq_v), .i_ray(sq_ray), .i_root(root),
        .o_valid(out_v), .o_x(ox), .o_y(oy), .o_z(oz), .o_reflect(refl)
    );

    assign m_axis_tvalid = out_v;
    assign m_axis_tdata  = {2'b00, oz, oy, ox};
    assign m_axis_tuser  = refl;
endmodule

### design/srd_checker.sv
// Port-level checks of the refraction block and their binding to the top level.
`include "snell_refraction_direction_assert.svh"

module srd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata,
    input logic         m_axis_tuser
);
    `SRD_ASSERT_NOW(a_reflect_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 56'd0)
    `SRD_ASSERT_NOW(a_ready_when_free, !m_axis_tvalid || m_axis_tready, s_axis_tready)
    `SRD_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SRD_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
endmodule

bind snell_refraction_direction srd_checker u_srd_checker (.*);
